// ----- hw/rtl/gqg_pkg.sv -----
// ----------------------------------------------------------------------------
// gqg_pkg
// Shared types and constants of the glyph quad generator.
// ----------------------------------------------------------------------------
package gqg_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned TEX_W       = 17;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUAD_VERTS  = 6;
  localparam int unsigned VIDX_W      = 3;

  localparam logic [CODE_W-1:0] ATLAS_FIRST  = 8'd32;
  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0]  CELL_W_RST  = 8'd32;
  localparam logic [7:0]  CELL_H_RST  = 8'd32;
  localparam logic [7:0]  GLYPH_W_RST = 8'd16;
  localparam logic [7:0]  GLYPH_H_RST = 8'd32;
  localparam logic [12:0] TEX_H_RST   = 13'd512;
  localparam logic [15:0] SCALE_RST   = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_PITCH      = 3'd0,
    REG_ROW_PITCH      = 3'd1,
    REG_GLYPH_WIDTH    = 3'd2,
    REG_GLYPH_HEIGHT   = 3'd3,
    REG_TEXTURE_HEIGHT = 3'd4,
    REG_SCALE_FACTOR   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  col_pitch;
    logic [7:0]  row_pitch;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [12:0] texture_height;
    logic [15:0] scale_factor;
  } cfg_t;

  // one queued glyph: screen corners and atlas cell
  typedef struct packed {
    logic [POS_W-1:0]  x0;
    logic [POS_W-1:0]  x1;
    logic [POS_W-1:0]  y0;
    logic [POS_W-1:0]  y1;
    logic [CODE_W-1:0] col;
    logic [CODE_W-1:0] row;
  } quad_t;

  typedef enum logic [1:0] {
    ITEM_START   = 2'd0,
    ITEM_NEWLINE = 2'd1,
    ITEM_DROP    = 2'd2,
    ITEM_GLYPH   = 2'd3
  } item_kind_e;

endpackage

// ----- hw/rtl/glyph_quad_generator_core.sv -----
// ----------------------------------------------------------------------------
// glyph_quad_generator_core
// Turns text characters into textured quads for a grid font atlas.
// ----------------------------------------------------------------------------
// The front end handles each request in the cycle it is accepted. A start
// request loads the pen, a newline lowers it, control codes are dropped;
// none of these gives output. A printable code is queued (two entries) and
// the back end sends its six vertices through a single output register, one
// vertex per cycle while the receiver is ready; the output limits the glyph
// stream. A glyph passes the queue entry, the working quad and the output
// register. The user must write registers on the configuration channel only
// while no glyph is in flight; the core itself does not enforce this.
module glyph_quad_generator_core #(
  parameter int unsigned ATLAS_COLUMNS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gqg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gqg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // characters
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [71:0]                      s_axis_tdata,  // char_code, start_x, start_y
  input  logic [0:0]                       s_axis_tuser,  // opcode
  // vertices
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [103:0]                     m_axis_tdata,  // vertex_x, vertex_y, tex_u, tex_v
  output logic                             m_axis_tlast   // last_vertex
);
  import gqg_pkg::*;

  cfg_t        cfg_q;
  logic        push, pop, full, avail;
  quad_t       push_data, head;
  logic [31:0] vx, vy;
  logic [16:0] tu, tv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_pitch      <= CELL_W_RST;
      cfg_q.row_pitch      <= CELL_H_RST;
      cfg_q.glyph_width    <= GLYPH_W_RST;
      cfg_q.glyph_height   <= GLYPH_H_RST;
      cfg_q.texture_height <= TEX_H_RST;
      cfg_q.scale_factor   <= SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COL_PITCH:      cfg_q.col_pitch      <= cfg_data_i[7:0];
        REG_ROW_PITCH:      cfg_q.row_pitch      <= cfg_data_i[7:0];
        REG_GLYPH_WIDTH:    cfg_q.glyph_width    <= cfg_data_i[7:0];
        REG_GLYPH_HEIGHT:   cfg_q.glyph_height   <= cfg_data_i[7:0];
        REG_TEXTURE_HEIGHT: cfg_q.texture_height <= cfg_data_i[12:0];
        REG_SCALE_FACTOR:   cfg_q.scale_factor   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gqg_front #(
    .ATLAS_COLUMNS(ATLAS_COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_valid_i  (s_axis_tvalid),
    .opcode_i     (s_axis_tuser[0]),
    .char_code_i  (s_axis_tdata[7:0]),
    .start_x_i    (s_axis_tdata[39:8]),
    .start_y_i    (s_axis_tdata[71:40]),
    .queue_full_i (full),
    .req_ready_o  (s_axis_tready),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  gqg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .avail_o     (avail),
    .head_o      (head)
  );

  gqg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .avail_i       (avail),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .vertex_x_o    (vx),
    .vertex_y_o    (vy),
    .tex_u_o       (tu),
    .tex_v_o       (tv),
    .last_vertex_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, tv, tu, vy, vx};

endmodule

// ----- hw/rtl/gqg_front.sv -----
// ----------------------------------------------------------------------------
// gqg_front
// Takes requests, classifies them, keeps the pen and queues glyph quads.
// ----------------------------------------------------------------------------
module gqg_front #(
  parameter int unsigned ATLAS_COLUMNS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gqg_pkg::cfg_t       cfg_i,
  input  logic                req_valid_i,
  input  logic                opcode_i,
  input  logic [7:0]          char_code_i,
  input  logic [31:0]         start_x_i,
  input  logic [31:0]         start_y_i,
  input  logic                queue_full_i,
  output logic                req_ready_o,
  output logic                push_o,
  output gqg_pkg::quad_t      push_data_o
);
  import gqg_pkg::*;

  typedef logic [2*CODE_W-1:0] cr_tab_t [2**CODE_W];

  // {row, col} of every atlas index, settled at elaboration
  function automatic cr_tab_t build_tab();
    cr_tab_t t;
    for (int i = 0; i < 2**CODE_W; i++) begin
      t[i] = {CODE_W'(i / ATLAS_COLUMNS), CODE_W'(i % ATLAS_COLUMNS)};
    end
    return t;
  endfunction

  localparam cr_tab_t CR_TAB = build_tab();

  logic [POS_W-1:0]    pen_x_q, pen_x_d;
  logic [POS_W-1:0]    pen_y_q, pen_y_d;
  item_kind_e          kind;
  logic                accept;
  logic [7:0]          mul_a;
  logic [23:0]         prod_a;
  logic [23:0]         prod_h;
  logic [POS_W-1:0]    len_a;
  logic [POS_W-1:0]    len_h;
  logic [CODE_W-1:0]   id;
  logic [2*CODE_W-1:0] cr;

  assign req_ready_o = !queue_full_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    if (!opcode_i) begin
      kind = ITEM_START;
    end else if (char_code_i == NEWLINE_CODE) begin
      kind = ITEM_NEWLINE;
    end else if (char_code_i < ATLAS_FIRST) begin
      kind = ITEM_DROP;
    end else begin
      kind = ITEM_GLYPH;
    end
  end

  // texel count times Q8.8 scale: Q16.8 lengths, moved to Q16.16
  assign mul_a  = (kind == ITEM_NEWLINE) ? cfg_i.row_pitch : cfg_i.glyph_width;
  assign prod_a = 24'(mul_a) * 24'(cfg_i.scale_factor);
  assign prod_h = 24'(cfg_i.glyph_height) * 24'(cfg_i.scale_factor);
  assign len_a  = {prod_a, 8'h00};
  assign len_h  = {prod_h, 8'h00};

  assign id = char_code_i - ATLAS_FIRST;
  assign cr = CR_TAB[id];

  always_comb begin
    push_data_o.x0  = pen_x_q;
    push_data_o.x1  = pen_x_q + len_a;
    push_data_o.y0  = pen_y_q;
    push_data_o.y1  = pen_y_q + len_h;
    push_data_o.row = cr[2*CODE_W-1:CODE_W];
    push_data_o.col = cr[CODE_W-1:0];
  end

  assign push_o = accept && (kind == ITEM_GLYPH);

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (accept) begin
      unique case (kind)
        ITEM_START: begin
          pen_x_d = start_x_i;
          pen_y_d = start_y_i;
        end
        ITEM_NEWLINE: pen_y_d = pen_y_q - len_a;
        ITEM_GLYPH:   pen_x_d = push_data_o.x1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

endmodule

// ----- hw/rtl/gqg_queue.sv -----
// ----------------------------------------------------------------------------
// gqg_queue
// Short queue of glyph quads between front and back.
// ----------------------------------------------------------------------------
module gqg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gqg_pkg::quad_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           avail_o,
  output gqg_pkg::quad_t head_o
);
  import gqg_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  quad_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign avail_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/gqg_back.sv -----
// ----------------------------------------------------------------------------
// gqg_back
// Loads a queued quad, works out its texels and sends six vertices.
// ----------------------------------------------------------------------------
module gqg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gqg_pkg::cfg_t  cfg_i,
  input  logic           avail_i,
  input  gqg_pkg::quad_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    vertex_x_o,
  output logic [31:0]    vertex_y_o,
  output logic [16:0]    tex_u_o,
  output logic [16:0]    tex_v_o,
  output logic           last_vertex_o
);
  import gqg_pkg::*;

  localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(QUAD_VERTS - 1);
  localparam logic [VIDX_W-1:0] V0 = VIDX_W'(0);
  localparam logic [VIDX_W-1:0] V1 = VIDX_W'(1);
  localparam logic [VIDX_W-1:0] V2 = VIDX_W'(2);
  localparam logic [VIDX_W-1:0] V3 = VIDX_W'(3);
  localparam logic [VIDX_W-1:0] V4 = VIDX_W'(4);

  // working quad
  logic                 quad_valid_q, quad_valid_d;
  logic [POS_W-1:0]     x0_q, x1_q, y0_q, y1_q;
  logic [TEX_W-1:0]     ul_q, ur_q, vu_q, vl_q;
  logic [TEX_W-1:0]     ul_d, ur_d, vu_d, vl_d;
  logic [15:0]          u_prod, v_prod;
  logic [VIDX_W-1:0]    vidx_q, vidx_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_free, emit, quad_done, load;
  logic [POS_W-1:0]     sel_x, sel_y;
  logic [TEX_W-1:0]     sel_u, sel_v;

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = quad_valid_q && out_free;
  assign quad_done = emit && (vidx_q == VIDX_LAST);
  assign load      = avail_i && (!quad_valid_q || quad_done);
  assign pop_o     = load;

  assign u_prod = 16'(cfg_i.col_pitch) * 16'(head_i.col);
  assign v_prod = 16'(cfg_i.row_pitch) * 16'(head_i.row);
  assign ul_d   = TEX_W'(u_prod);
  assign ur_d   = ul_d + TEX_W'(cfg_i.glyph_width);
  assign vu_d   = TEX_W'(cfg_i.texture_height) - TEX_W'(v_prod);
  assign vl_d   = vu_d - TEX_W'(cfg_i.row_pitch);

  always_comb begin
    quad_valid_d = quad_valid_q;
    if (load) begin
      quad_valid_d = 1'b1;
    end else if (quad_done) begin
      quad_valid_d = 1'b0;
    end
    vidx_d = vidx_q;
    if (emit) begin
      vidx_d = quad_done ? '0 : vidx_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // two triangles: lower left, upper left, upper right, then lower left, upper right, lower right
  always_comb begin
    case (vidx_q) inside
      V0, V3: begin
        sel_x = x0_q; sel_y = y1_q; sel_u = ul_q; sel_v = vl_q;
      end
      V1: begin
        sel_x = x0_q; sel_y = y0_q; sel_u = ul_q; sel_v = vu_q;
      end
      V2, V4: begin
        sel_x = x1_q; sel_y = y0_q; sel_u = ur_q; sel_v = vu_q;
      end
      default: begin
        sel_x = x1_q; sel_y = y1_q; sel_u = ur_q; sel_v = vl_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_valid_q <= 1'b0;
      vidx_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      quad_valid_q <= quad_valid_d;
      vidx_q       <= vidx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x0_q <= head_i.x0;
      x1_q <= head_i.x1;
      y0_q <= head_i.y0;
      y1_q <= head_i.y1;
      ul_q <= ul_d;
      ur_q <= ur_d;
      vu_q <= vu_d;
      vl_q <= vl_d;
    end
    if (emit) begin
      vertex_x_o    <= sel_x;
      vertex_y_o    <= sel_y;
      tex_u_o       <= sel_u;
      tex_v_o       <= sel_v;
      last_vertex_o <= (vidx_q == VIDX_LAST);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/gqg_checker.sv -----
// ----------------------------------------------------------------------------
// gqg_checker
// Port-level checks on the vertex stream of the glyph quad generator.
// ----------------------------------------------------------------------------
module gqg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  import gqg_pkg::*;

  localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(QUAD_VERTS - 1);

  logic               acc;
  logic [VIDX_W-1:0]  cnt_q;
  logic [103:0]       first_q, third_q;

  assign acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      cnt_q <= (cnt_q == VIDX_LAST) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && cnt_q == VIDX_W'(0)) begin
      first_q <= m_axis_tdata;
    end
    if (acc && cnt_q == VIDX_W'(2)) begin
      third_q <= m_axis_tdata;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("vertex withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("vertex changed while stalled");

  a_last_sixth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (m_axis_tlast == (cnt_q == VIDX_LAST)))
    else $error("tlast not on sixth vertex");

  a_fourth_repeats_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cnt_q == VIDX_W'(3) |-> m_axis_tdata == first_q)
    else $error("fourth vertex differs from first");

  a_fifth_repeats_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cnt_q == VIDX_W'(4) |-> m_axis_tdata == third_q)
    else $error("fifth vertex differs from third");

endmodule

bind glyph_quad_generator_core gqg_checker u_gqg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for glyph_quad_generator_core.
// ----------------------------------------------------------------------------
// Character requests go out from a queue on the slave stream. Each accepted
// request is run through a local pen and atlas predictor, which queues the
// six vertices that a printable code should give. Every vertex taken from
// the master stream is checked field by field against the oldest queued one.
// Register settings change between phases while the core is idle: reset
// values, all-ones, minimum with zero scale, and random. Sender and receiver
// stall at random, and one long receiver hold-off backs up the core.
// ----------------------------------------------------------------------------
module testbench;
  import gqg_pkg::*;

  localparam int unsigned COLUMNS = 16;
  localparam logic OP_START = 1'b0;
  localparam logic OP_CHAR  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 48;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic        op;
    logic [7:0]  code;
    logic [31:0] sx;
    logic [31:0] sy;
  } char_req_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [16:0] u;
    logic [16:0] v;
    logic        last;
  } vertex_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;  // char_code, start_x, start_y
  logic [0:0]   s_axis_tuser;  // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;  // vertex_x, vertex_y, tex_u, tex_v
  logic         m_axis_tlast;  // last_vertex

  char_req_t pending_chars[$];
  vertex_t   expected_vertices[$];

  // predictor state and register mirror
  logic [31:0] pen_x = '0;
  logic [31:0] pen_y = '0;
  logic [7:0]  cell_w_m  = CELL_W_RST;
  logic [7:0]  cell_h_m  = CELL_H_RST;
  logic [7:0]  glyph_w_m = GLYPH_W_RST;
  logic [7:0]  glyph_h_m = GLYPH_H_RST;
  logic [12:0] tex_h_m   = TEX_H_RST;
  logic [15:0] scale_m   = SCALE_RST;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned rx_hold_left = 0;
  int unsigned bad_vertices = 0;
  logic        char_taken = 1'b0;

  glyph_quad_generator_core #(
    .ATLAS_COLUMNS(COLUMNS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // length of a texel count at Q8.8 scale, as Q16.16 modulo 2^32
  function automatic logic [31:0] scaled_len(input logic [7:0] texels);
    logic [31:0] prod;
    prod = 32'(texels) * 32'(scale_m);
    return prod << 8;
  endfunction

  task automatic push_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] u, input logic [31:0] v,
                             input logic last);
    vertex_t vx;
    vx.x = x;
    vx.y = y;
    vx.u = u[16:0];
    vx.v = v[16:0];
    vx.last = last;
    expected_vertices.push_back(vx);
  endtask

  task automatic render_char(input char_req_t rq);
    logic [31:0] id, col, row, ul, ur, vu, vl, x1, y1;
    if (rq.op == OP_START) begin
      pen_x = rq.sx;
      pen_y = rq.sy;
    end else if (rq.code == NEWLINE_CODE) begin
      pen_y = pen_y - scaled_len(cell_h_m);
    end else if (rq.code >= ATLAS_FIRST) begin
      id  = 32'(rq.code) - 32'(ATLAS_FIRST);
      col = id % COLUMNS;
      row = id / COLUMNS;
      ul  = 32'(cell_w_m) * col;
      ur  = ul + 32'(glyph_w_m);
      vu  = 32'(tex_h_m) - 32'(cell_h_m) * row;
      vl  = vu - 32'(cell_h_m);
      x1  = pen_x + scaled_len(glyph_w_m);
      y1  = pen_y + scaled_len(glyph_h_m);
      push_vertex(pen_x, y1,    ul, vl, 1'b0);
      push_vertex(pen_x, pen_y, ul, vu, 1'b0);
      push_vertex(x1,    pen_y, ur, vu, 1'b0);
      push_vertex(pen_x, y1,    ul, vl, 1'b0);
      push_vertex(x1,    pen_y, ur, vu, 1'b0);
      push_vertex(x1,    y1,    ur, vl, 1'b1);
      pen_x = x1;
    end
  endtask

  // sender
  always @(negedge clk_i) begin : feed
    char_req_t rq;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || char_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        rq = pending_chars.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.sy, rq.sx, rq.code};
        s_axis_tuser  <= rq.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: register mirror, prediction and vertex check
  always @(posedge clk_i) begin : watch
    char_req_t rq;
    vertex_t   exp_v;
    vertex_t   got_v;
    if (rst_ni) begin
      char_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_COL_PITCH:      cell_w_m  = cfg_data_i[7:0];
          REG_ROW_PITCH:      cell_h_m  = cfg_data_i[7:0];
          REG_GLYPH_WIDTH:    glyph_w_m = cfg_data_i[7:0];
          REG_GLYPH_HEIGHT:   glyph_h_m = cfg_data_i[7:0];
          REG_TEXTURE_HEIGHT: tex_h_m   = cfg_data_i[12:0];
          REG_SCALE_FACTOR:   scale_m   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_v.x    = m_axis_tdata[31:0];
        got_v.y    = m_axis_tdata[63:32];
        got_v.u    = m_axis_tdata[80:64];
        got_v.v    = m_axis_tdata[97:81];
        got_v.last = m_axis_tlast;
        if (expected_vertices.size() == 0) begin
          bad_vertices++;
          if (bad_vertices <= 10)
            $display("unexpected vertex: x=%h y=%h u=%h v=%h last=%b",
                     got_v.x, got_v.y, got_v.u, got_v.v, got_v.last);
        end else begin
          exp_v = expected_vertices.pop_front();
          if (got_v != exp_v) begin
            bad_vertices++;
            if (bad_vertices <= 10)
              $display("vertex wrong: exp %h %h %h %h %b, got %h %h %h %h %b",
                       exp_v.x, exp_v.y, exp_v.u, exp_v.v, exp_v.last,
                       got_v.x, got_v.y, got_v.u, got_v.v, got_v.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.op   = s_axis_tuser[0];
        rq.code = s_axis_tdata[7:0];
        rq.sx   = s_axis_tdata[39:8];
        rq.sy   = s_axis_tdata[71:40];
        render_char(rq);
      end
    end
  end

  task automatic queue_char(input logic op, input logic [7:0] code,
                            input logic [31:0] sx, input logic [31:0] sy);
    char_req_t rq;
    rq.op = op;
    rq.code = code;
    rq.sx = sx;
    rq.sy = sy;
    pending_chars.push_back(rq);
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned r;
    logic [7:0]  code;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8)       code = 8'($urandom);
      else if (r < 18) code = NEWLINE_CODE;
      else if (r < 23) code = 8'($urandom_range(31));
      else             code = 8'($urandom_range(255, 32));
      queue_char((r < 8) ? OP_START : OP_CHAR, code, $urandom, $urandom);
    end
  endtask

  // all requests taken, all vertices seen, then a quiet settling wait
  task automatic drain();
    while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_config(input logic [15:0] cw, input logic [15:0] ch,
                              input logic [15:0] gw, input logic [15:0] gh,
                              input logic [15:0] th, input logic [15:0] sc);
    write_reg(IDX_UNMAPPED_LO, 16'($urandom));
    write_reg(REG_COL_PITCH, cw);
    write_reg(REG_ROW_PITCH, ch);
    write_reg(REG_GLYPH_WIDTH, gw);
    write_reg(REG_GLYPH_HEIGHT, gh);
    write_reg(REG_TEXTURE_HEIGHT, th);
    write_reg(REG_SCALE_FACTOR, sc);
    write_reg(IDX_UNMAPPED_HI, 16'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 19;
    rx_idle_pct = 77;

    // directed: reset pen, atlas corners, control codes, pen wrap
    queue_char(OP_CHAR,  8'd65,  $urandom, $urandom);
    queue_char(OP_START, 8'($urandom), 32'h7FFF_0000, 32'h8000_0000);
    queue_char(OP_CHAR,  8'd32,  $urandom, $urandom);
    queue_char(OP_CHAR,  8'd47,  $urandom, $urandom);
    queue_char(OP_CHAR,  8'd255, $urandom, $urandom);
    queue_char(OP_CHAR,  NEWLINE_CODE, $urandom, $urandom);
    queue_char(OP_CHAR,  8'd0,   $urandom, $urandom);
    queue_char(OP_CHAR,  8'd31,  $urandom, $urandom);
    queue_char(OP_CHAR,  8'd9,   $urandom, $urandom);
    queue_char(OP_CHAR,  8'd126, $urandom, $urandom);
    queue_char(OP_START, 8'hFF,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_char(OP_CHAR,  8'd128, $urandom, $urandom);
    queue_char(OP_CHAR,  8'd200, $urandom, $urandom);
    queue_char(OP_CHAR,  NEWLINE_CODE, $urandom, $urandom);
    queue_char(OP_START, NEWLINE_CODE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_char(OP_CHAR,  8'd48,  $urandom, $urandom);
    queue_char(OP_CHAR,  8'd33,  $urandom, $urandom);
    queue_char(OP_START, 8'd0,   32'h0000_0000, 32'h0000_0000);
    queue_char(OP_CHAR,  8'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // all-ones settings, with the long hold-off to back the core up
    write_config(16'hFFFF, 16'h00FF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'hFFFF);
    rx_hold_left = 300;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // minimum settings, zero scale
    write_config(16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0001, 16'h0000);
    queue_random(RANDOM_PER_PHASE);
    drain();

    tx_idle_pct = 77;
    rx_idle_pct = 19;
    repeat (2) begin
      write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      queue_random(RANDOM_PER_PHASE);
      drain();
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(4096, 1)), 16'($urandom_range(1024)));
    queue_random(RANDOM_PER_PHASE);
    drain();

    write_config(16'(CELL_W_RST), 16'(CELL_H_RST), 16'(GLYPH_W_RST),
                 16'(GLYPH_H_RST), 16'(TEX_H_RST), SCALE_RST);
    queue_random(RANDOM_PER_PHASE);
    drain();

    if (bad_vertices == 0 && expected_vertices.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
